/* src/awob_pkg.sv */
// package for the additive wavetable oscillator bank
// holds sizes, command codes and register indexes; no dependencies
package awob_pkg;
    localparam int NUM_OSC = 128;
    localparam int TABLE_DEPTH = 1024;
    localparam int OSC_W = $clog2(NUM_OSC);
    localparam int TAB_W = $clog2(TABLE_DEPTH);
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_TABLE = 2'd2;
    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_STEP = 1'b1;
    localparam logic [30:0] ENV_ONE = 31'd65536;
endpackage

/* src/additive_wavetable_oscillator_bank.sv */
// top level of the additive wavetable oscillator bank
// depends on awob_pkg
//
// Set and table transactions can follow back to back. A tick transaction
// walks the NUM_OSC oscillators through one shared multiplier. An oscillator
// that is stopped with its envelope at or below one is only read and checked.
// A live one goes through read, gain times error, envelope, wave times
// envelope, accumulate and write back. The mix is then clipped in S_DONE.
// Before any table word is written a tick goes straight to the clip step.
// s_tready is low during a tick. A tick whose previous result is still held
// waits in its clip step until that result is taken. After reset a clearing
// pass over all NUM_OSC oscillators zeroes their state, with s_tready low.
// s_tdata from bit 0: command[1:0], osc_index[8:2], play[9],
// amp_target[24:10], wave_addr[34:25], table_value[50:35].
// m_tdata: sample_out[15:0]; m_tuser: clipped.
module additive_wavetable_oscillator_bank
    import awob_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // command, osc_index, play, amp_target, wave_addr, table_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample_out
    output logic        m_tuser    // clipped
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD, S_CHK, S_ENV, S_MUL, S_ACC, S_DONE
    } state_t;
    state_t state_reg;

    logic [15:0] gain_reg;
    logic [31:0] step_reg;
    logic        loaded_reg;
    logic [OSC_W-1:0] k_reg;
    logic [31:0] inc_reg;          // k * step accumulated
    logic signed [23:0] mix_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        out_clip_reg;

    // oscillator memories: phase and envelope, play flag and target
    logic [62:0] osc_state_mem [NUM_OSC];
    logic [15:0] osc_ctl_mem [NUM_OSC];
    logic [15:0] wave_mem [TABLE_DEPTH];
    logic [62:0] state_rd_reg;
    logic [15:0] ctl_rd_reg;
    logic signed [15:0] w_reg;
    logic signed [49:0] prod_reg;
    logic signed [31:0] tap_reg;
    logic [30:0] env_new_reg;

    logic [1:0]  cmd;
    logic [31:0] ph;
    logic [30:0] env;
    logic        pl;
    logic [14:0] tg;
    logic        skip;
    logic        k_last;
    logic        set_acc;
    logic        table_acc;
    logic        out_load;
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] mul_p;
    logic signed [32:0] err;
    logic signed [33:0] env_sum;
    logic signed [23:0] mix_add;

    assign cmd = s_tdata[1:0];
    assign ph = state_rd_reg[62:31];
    assign env = state_rd_reg[30:0];
    assign pl = ctl_rd_reg[15];
    assign tg = ctl_rd_reg[14:0];
    assign skip = !pl && (env <= ENV_ONE);
    assign k_last = (k_reg == OSC_W'(NUM_OSC - 1));

    assign s_tready = (state_reg == S_IDLE);
    assign set_acc = s_tvalid && s_tready && (cmd == CMD_SET);
    assign table_acc = s_tvalid && s_tready && (cmd == CMD_TABLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    // shared multiplier: gain*err then wave*env
    assign err = $signed({2'b00, (pl ? tg : 15'd0), 16'd0}) - $signed({2'b00, env});
    always_comb begin
        if (state_reg == S_MUL) begin
            mul_a = $signed({{17{w_reg[15]}}, w_reg});
            mul_b = $signed({2'b00, env_new_reg[30:16]});
        end else begin
            mul_a = err;
            mul_b = $signed({1'b0, gain_reg});
        end
    end
    assign mul_p = mul_a * mul_b;

    assign env_sum = $signed({3'b000, env}) + $signed(prod_reg[49:16]);
    assign mix_add = mix_reg + $signed({{9{tap_reg[31]}}, tap_reg[31:17]});

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_clip_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == S_CLEAR) begin
            osc_state_mem[k_reg] <= '0;
        end else if (state_reg == S_ACC) begin
            osc_state_mem[k_reg] <= {ph + inc_reg, env_new_reg};
        end
        if (state_reg == S_CLEAR) begin
            osc_ctl_mem[k_reg] <= '0;
        end else if (set_acc) begin
            osc_ctl_mem[s_tdata[8:2]] <= {s_tdata[9], s_tdata[24:10]};
        end
        if (table_acc) wave_mem[s_tdata[34:25]] <= s_tdata[50:35];
        state_rd_reg <= osc_state_mem[k_reg];
        ctl_rd_reg <= osc_ctl_mem[k_reg];
        w_reg <= $signed(wave_mem[ph[31 -: TAB_W]]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            k_reg <= '0;
            inc_reg <= '0;
            mix_reg <= '0;
            loaded_reg <= 1'b0;
            gain_reg <= 16'd6554;
            step_reg <= '0;
            prod_reg <= '0;
            tap_reg <= '0;
            env_new_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
            out_clip_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_GAIN) gain_reg <= cfg_wdata[15:0];
                else step_reg <= cfg_wdata;
            end
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_last) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        if (cmd == CMD_TABLE) begin
                            loaded_reg <= 1'b1;
                        end else if (cmd == CMD_TICK) begin
                            mix_reg <= '0;
                            inc_reg <= '0;
                            k_reg <= '0;
                            state_reg <= loaded_reg ? S_RD : S_DONE;
                        end
                    end
                end
                S_RD: state_reg <= S_CHK;   // records land in the read registers
                S_CHK: begin
                    if (skip) begin
                        k_reg <= k_reg + 1'b1;
                        inc_reg <= inc_reg + step_reg;
                        state_reg <= k_last ? S_DONE : S_RD;
                    end else begin
                        prod_reg <= mul_p;
                        state_reg <= S_ENV;
                    end
                end
                S_ENV: begin
                    env_new_reg <= env_sum[33] ? 31'd0 : env_sum[30:0];
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    tap_reg <= mul_p[31:0];
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    // floor by 4 then by 32768 is one arithmetic shift by 17
                    mix_reg <= mix_add;
                    k_reg <= k_reg + 1'b1;
                    inc_reg <= inc_reg + step_reg;
                    state_reg <= k_last ? S_DONE : S_RD;
                end
                S_DONE: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                        if (mix_reg > 24'sd32767) begin
                            out_data_reg <= 16'h7fff;
                            out_clip_reg <= 1'b1;
                        end else if (mix_reg < -24'sd32767) begin
                            out_data_reg <= 16'h8001;
                            out_clip_reg <= 1'b1;
                        end else begin
                            out_data_reg <= mix_reg[15:0];
                            out_clip_reg <= 1'b0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
